FILE: rtl/core/ordered_list_store_engine_unit_assert.svh
// assertion macros used by the checker
`ifndef ORDERED_LIST_STORE_ENGINE_UNIT_ASSERT_SVH
`define ORDERED_LIST_STORE_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define OLSE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define OLSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/olse_pkg.sv
package olse_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ACT_APPEND       = 3'd0,
    ACT_INSERT_AT    = 3'd1,
    ACT_REMOVE_AT    = 3'd2,
    ACT_REMOVE_VALUE = 3'd3,
    ACT_FIND_NTH     = 3'd4,
    ACT_FIND_LAST    = 3'd5,
    ACT_SORT         = 3'd6,
    ACT_CLEAR        = 3'd7
  } act_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic signed [6:0] NO_INDEX = -7'sd1;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

FILE: rtl/core/olse_cmp.sv
// shared value comparator: equality for searches, greater-than for sort
module olse_cmp import olse_pkg::*; (
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  output cmp_res_t               res
);

  assign res.eq = (a == b);
  assign res.gt = (a > b);

endmodule

FILE: rtl/core/ordered_list_store_engine_unit.sv
// Ordered list of up to 64 unsigned 32-bit values held in a single-port-read
// RAM, driven by a small sequencer around one shared comparator. One beat in
// gives one beat out. Append, clear and failing checks go straight to the
// done state; insert and remove move one entry at a time, a RAM read then a
// write; searches read one entry at a time; sort is a bubble sort. The RAM's
// registered read puts a read state before each move or compare. in_ready is
// high only while the sequencer is idle; a finished result waits in the
// output register while the next beat is taken.
module ordered_list_store_engine_unit import olse_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_action,
  input  logic [5:0]               in_position,
  input  logic [31:0]              in_item_value,
  input  logic [6:0]               in_occurrence,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic signed [6:0]        out_found_index,
  output logic [31:0]              out_removed_value,
  output logic [6:0]               out_entry_count
);

  // sequencer states
  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_SHUP     = 13'b0000000000010,
    S_SHUP_WR  = 13'b0000000000100,
    S_TAKE     = 13'b0000000001000,
    S_SHDN     = 13'b0000000010000,
    S_SHDN_WR  = 13'b0000000100000,
    S_SCAN     = 13'b0000001000000,
    S_SCAN_CHK = 13'b0000010000000,
    S_SORT_LD  = 13'b0000100000000,
    S_SORT_LDW = 13'b0001000000000,
    S_SORT     = 13'b0010000000000,
    S_SORT_CMP = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // entry memory
  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic [ADDR_W-1:0]      rd_addr, wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic                   we;

  // control and working registers
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  act_t                   act_r, act_nxt;
  logic [ADDR_W-1:0]      pos_r, pos_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [6:0]             occ_r, occ_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       lim_r, lim_nxt;
  logic [6:0]             seen_r, seen_nxt;
  logic [VALUE_WIDTH-1:0] hold_r, hold_nxt;
  logic [1:0]             res_status_r, res_status_nxt;
  logic signed [6:0]      res_found_r, res_found_nxt;
  logic [31:0]            res_removed_r, res_removed_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_status_r;
  logic signed [6:0]      out_found_r;
  logic [31:0]            out_removed_r;
  logic [6:0]             out_count_r;
  logic                   out_load;

  logic [CNT_W-1:0]       idx_p1, idx_m1;
  logic [6:0]             seen_p1;
  logic                   sort_phase;
  logic [VALUE_WIDTH-1:0] cmp_a;
  cmp_res_t               cmp;

  assign idx_p1  = idx_r + 1'b1;
  assign idx_m1  = idx_r - 1'b1;
  assign seen_p1 = seen_r + 7'd1;

  // the comparator checks the search key, or the carried sort value
  assign sort_phase = (state_r == S_SORT_CMP);
  assign cmp_a      = sort_phase ? hold_r : val_r;

  olse_cmp u_cmp (
    .a   (cmp_a),
    .b   (rd_data_r),
    .res (cmp)
  );

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    act_nxt         = act_r;
    pos_nxt         = pos_r;
    val_nxt         = val_r;
    occ_nxt         = occ_r;
    idx_nxt         = idx_r;
    lim_nxt         = lim_r;
    seen_nxt        = seen_r;
    hold_nxt        = hold_r;
    res_status_nxt  = res_status_r;
    res_found_nxt   = res_found_r;
    res_removed_nxt = res_removed_r;
    rd_addr         = idx_r[ADDR_W-1:0];
    wr_addr         = idx_r[ADDR_W-1:0];
    wr_data         = rd_data_r;
    we              = 1'b0;
    out_load        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt         = act_t'(in_action);
          pos_nxt         = in_position;
          val_nxt         = in_item_value;
          occ_nxt         = in_occurrence;
          res_status_nxt  = ST_OK;
          res_found_nxt   = NO_INDEX;
          res_removed_nxt = '0;
          idx_nxt         = '0;
          seen_nxt        = '0;
          state_nxt       = S_DONE;
          unique case (act_t'(in_action))
            ACT_APPEND: begin
              if (cnt_r == CNT_W'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
              end else begin
                we      = 1'b1;
                wr_addr = cnt_r[ADDR_W-1:0];
                wr_data = in_item_value;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            ACT_INSERT_AT: begin
              if (cnt_r == CNT_W'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
              end else if ({1'b0, in_position} > cnt_r) begin
                res_status_nxt = ST_BAD_INDEX;
              end else begin
                idx_nxt   = cnt_r;
                state_nxt = S_SHUP;
              end
            end
            ACT_REMOVE_AT: begin
              if ({1'b0, in_position} >= cnt_r) begin
                res_status_nxt = ST_BAD_INDEX;
              end else begin
                idx_nxt   = {1'b0, in_position};
                rd_addr   = in_position;
                state_nxt = S_TAKE;
              end
            end
            ACT_REMOVE_VALUE, ACT_FIND_NTH, ACT_FIND_LAST: begin
              res_status_nxt = ST_NOT_FOUND;
              state_nxt      = S_SCAN;
            end
            ACT_SORT: begin
              if (cnt_r >= CNT_W'(2)) begin
                lim_nxt   = cnt_r - 1'b1;
                state_nxt = S_SORT_LD;
              end
            end
            ACT_CLEAR: begin
              cnt_nxt = '0;
            end
          endcase
        end
      end

      // make room: move entries up from the end down to the insert point
      S_SHUP: begin
        if (idx_r == {1'b0, pos_r}) begin
          we        = 1'b1;
          wr_addr   = pos_r;
          wr_data   = val_r;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_addr   = idx_m1[ADDR_W-1:0];
          state_nxt = S_SHUP_WR;
        end
      end
      S_SHUP_WR: begin
        we        = 1'b1;
        idx_nxt   = idx_m1;
        state_nxt = S_SHUP;
      end

      S_TAKE: begin
        res_removed_nxt = rd_data_r;
        state_nxt       = S_SHDN;
      end

      // close the gap: move later entries down by one
      S_SHDN: begin
        if (idx_p1 >= cnt_r) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_addr   = idx_p1[ADDR_W-1:0];
          state_nxt = S_SHDN_WR;
        end
      end
      S_SHDN_WR: begin
        we        = 1'b1;
        idx_nxt   = idx_p1;
        state_nxt = S_SHDN;
      end

      S_SCAN: begin
        if (idx_r >= cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        idx_nxt   = idx_p1;
        state_nxt = S_SCAN;
        if (cmp.eq) begin
          priority case (act_r)
            ACT_REMOVE_VALUE: begin
              res_status_nxt = ST_OK;
              res_found_nxt  = $signed(idx_r[6:0]);
              idx_nxt        = idx_r;
              state_nxt      = S_SHDN;
            end
            ACT_FIND_NTH: begin
              seen_nxt = seen_p1;
              if (seen_p1 == occ_r) begin
                res_status_nxt = ST_OK;
                res_found_nxt  = $signed(idx_r[6:0]);
                state_nxt      = S_DONE;
              end
            end
            default: begin
              // find last keeps the latest match
              res_status_nxt = ST_OK;
              res_found_nxt  = $signed(idx_r[6:0]);
            end
          endcase
        end
      end

      // bubble pass: carry the larger value toward the pass end
      S_SORT_LD: begin
        rd_addr   = '0;
        state_nxt = S_SORT_LDW;
      end
      S_SORT_LDW: begin
        hold_nxt  = rd_data_r;
        idx_nxt   = '0;
        state_nxt = S_SORT;
      end
      S_SORT: begin
        if (idx_r == lim_r) begin
          we      = 1'b1;
          wr_addr = lim_r[ADDR_W-1:0];
          wr_data = hold_r;
          lim_nxt = lim_r - 1'b1;
          if (lim_r == CNT_W'(1)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SORT_LD;
          end
        end else begin
          rd_addr   = idx_p1[ADDR_W-1:0];
          state_nxt = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        we        = 1'b1;
        wr_data   = cmp.gt ? rd_data_r : hold_r;
        hold_nxt  = cmp.gt ? hold_r : rd_data_r;
        idx_nxt   = idx_p1;
        state_nxt = S_SORT;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  assign out_valid_nxt = out_load | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    pos_r         <= pos_nxt;
    val_r         <= val_nxt;
    occ_r         <= occ_nxt;
    idx_r         <= idx_nxt;
    lim_r         <= lim_nxt;
    seen_r        <= seen_nxt;
    hold_r        <= hold_nxt;
    res_status_r  <= res_status_nxt;
    res_found_r   <= res_found_nxt;
    res_removed_r <= res_removed_nxt;
    if (out_load) begin
      out_status_r  <= res_status_r;
      out_found_r   <= res_found_r;
      out_removed_r <= res_removed_r;
      out_count_r   <= 7'(cnt_r);
    end
  end

  // entry ram, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found_index   = out_found_r;
  assign out_removed_value = out_removed_r;
  assign out_entry_count   = out_count_r;

endmodule

FILE: rtl/core/olse_checker.sv
`include "ordered_list_store_engine_unit_assert.svh"

module olse_checker import olse_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [2:0]        in_action,
  input logic [5:0]        in_position,
  input logic [31:0]       in_item_value,
  input logic [6:0]        in_occurrence,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_status,
  input logic signed [6:0] out_found_index,
  input logic [31:0]       out_removed_value,
  input logic [6:0]        out_entry_count
);

  logic        in_stall;
  logic        out_stall;
  logic [47:0] in_beat;
  logic [47:0] out_beat;

  assign in_stall  = in_valid && !in_ready;
  assign out_stall = out_valid && !out_ready;
  assign in_beat   = {in_action, in_position, in_item_value, in_occurrence};
  assign out_beat  = {out_status, out_found_index, out_removed_value, out_entry_count};

  // a stalled beat holds on either side
  `OLSE_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_beat))
  `OLSE_ASSERT_NEXT(a_in_hold, in_stall, in_valid && $stable(in_beat))

  // a full report only comes with a full list
  `OLSE_ASSERT_NOW(a_full_count, out_valid && out_status == ST_FULL, out_entry_count == 7'(CAPACITY))

  // a returned value or found index only on success
  `OLSE_ASSERT_NOW(a_removed_ok, out_valid && out_removed_value != 32'd0, out_status == ST_OK)
  `OLSE_ASSERT_NOW(a_found_ok, out_valid && out_found_index != NO_INDEX, out_status == ST_OK)

endmodule

bind ordered_list_store_engine_unit olse_checker u_olse_checker (.*);
